@@ sv/weighted_graph_merge_cost_engine_unit_defines.svh @@
// Assertion helpers for the merge cost engine
`ifndef WEIGHTED_GRAPH_MERGE_COST_ENGINE_UNIT_DEFINES_SVH
`define WEIGHTED_GRAPH_MERGE_COST_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define WGM_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset
`define WGM_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/wgm_pkg.sv @@
package wgm_pkg;

    // Default sizing
    localparam int MAX_NODES_DEF   = 64;
    localparam int WEIGHT_BITS_DEF = 32;

    // Field widths
    localparam int OP_W    = 3;
    localparam int NODE_W  = 6;
    localparam int VAL_W   = 32;
    localparam int COST_W  = 64;
    localparam int NCNT_W  = 7;
    localparam int SCALE_W = 16;
    localparam int CFG_W   = 32;
    localparam int CIDX_W  = 2;

    // Opcodes
    localparam logic [OP_W-1:0] OP_WRITE = 3'd0;
    localparam logic [OP_W-1:0] OP_READ  = 3'd1;
    localparam logic [OP_W-1:0] OP_MERGE = 3'd2;
    localparam logic [OP_W-1:0] OP_SPLIT = 3'd3;
    localparam logic [OP_W-1:0] OP_REPL  = 3'd4;
    localparam logic [OP_W-1:0] OP_FILL  = 3'd5;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_NODE_COUNT = 2'd0;
    localparam logic [CIDX_W-1:0] REG_COST_SCALE = 2'd1;
    localparam logic [CIDX_W-1:0] REG_ZERO_BONUS = 2'd2;

    // Register reset values
    localparam logic [NCNT_W-1:0]  NODE_COUNT_RST = 7'd64;
    localparam logic [SCALE_W-1:0] COST_SCALE_RST = 16'd1;

    // Shared unit modes
    typedef enum logic [1:0] {
        ALU_MFIRST = 2'd0,
        ALU_MERGE  = 2'd1,
        ALU_SPLIT  = 2'd2,
        ALU_REPL   = 2'd3
    } alu_mode_t;

endpackage

@@ sv/wgm_edge_mem.sv @@
module wgm_edge_mem
    import wgm_pkg::*;
#(
    parameter int DEPTH = 2016,
    parameter int AW    = 11,
    parameter int DW    = 32
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic [AW-1:0] rd_addr_a,
    input  logic [AW-1:0] rd_addr_b,
    output logic [DW-1:0] rd_data_a,
    output logic [DW-1:0] rd_data_b
);

    logic [DW-1:0] mem [DEPTH];

    // One write, two registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

@@ sv/wgm_cost_alu.sv @@
module wgm_cost_alu
    import wgm_pkg::*;
#(
    parameter int WEIGHT_BITS = 32
)
(
    input  alu_mode_t                mode,
    input  logic [WEIGHT_BITS-1:0]   e1,
    input  logic [WEIGHT_BITS-1:0]   e2,
    input  logic [WEIGHT_BITS-1:0]   val,
    input  logic signed [VAL_W-1:0]  bonus,
    output logic [WEIGHT_BITS-1:0]   w_new,
    output logic [WEIGHT_BITS-1:0]   mag,
    output logic [COST_W-1:0]        bonus_delta
);

    localparam int MW = WEIGHT_BITS + 1;

    logic signed [WEIGHT_BITS-1:0] e1_s, e2_s, v_s;
    logic signed [MW-1:0]          e1x, e2x, vx, sum_x, m_x;
    logic [COST_W-1:0]             b64;

    assign e1_s  = e1;
    assign e2_s  = e2;
    assign v_s   = val;
    assign e1x   = MW'(e1_s);
    assign e2x   = MW'(e2_s);
    assign vx    = MW'(v_s);
    assign sum_x = e1x + e2x;
    assign b64   = COST_W'(bonus);

    // Evaluate one edge pair
    always_comb
    begin
        m_x         = '0;
        bonus_delta = '0;
        w_new       = e1;
        case (mode)
            ALU_MFIRST:
            begin
                if (e1x < 0)
                begin
                    m_x = -e1x;
                end
                if (e1x == 0)
                begin
                    bonus_delta = b64;
                end
            end
            ALU_MERGE:
            begin
                if (e1x < 0 && e2x > 0)
                begin
                    m_x = (-e1x < e2x) ? -e1x : e2x;
                end
                else if (e1x > 0 && e2x < 0)
                begin
                    m_x = (e1x < -e2x) ? e1x : -e2x;
                end
                if (sum_x == 0)
                begin
                    bonus_delta = (e1x == 0) ? b64 : -b64;
                end
                else if (e1x == 0 || e2x == 0)
                begin
                    bonus_delta = b64;
                end
                w_new = sum_x[WEIGHT_BITS-1:0];
            end
            ALU_SPLIT:
            begin
                w_new = e1 - e2;
            end
            ALU_REPL:
            begin
                if (e1x < 0 && vx > 0)
                begin
                    m_x = -e1x;
                end
                else if (e1x > 0 && vx < 0)
                begin
                    m_x = e1x;
                end
                bonus_delta = ((e1x == 0) ? b64 : '0) - ((vx == 0) ? b64 : '0);
                w_new       = val;
            end
            default:
            begin
                w_new = e1;
            end
        endcase
    end

    assign mag = m_x[WEIGHT_BITS-1:0];

endmodule

@@ sv/weighted_graph_merge_cost_engine_unit.sv @@
// Merge and split scan the other nodes and update the edges of each live third
//   node; fill writes the value to every edge among the first n nodes.
// Throughput: one word at a time; the dual-read edge memory and the shared cost unit
//   set the per-node cost of merge and split, and the single multiplier that of merge.
// Reset: registers to defaults, all nodes live; then a clearing pass sets every
//   edge to -1.
`include "weighted_graph_merge_cost_engine_unit_defines.svh"
module weighted_graph_merge_cost_engine_unit
    import wgm_pkg::*;
#(
    parameter int MAX_NODES   = MAX_NODES_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_write,
    input  logic [CIDX_W-1:0]        cfg_index,
    input  logic [CFG_W-1:0]         cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [OP_W-1:0]          opcode,
    input  logic [NODE_W-1:0]        node_a,
    input  logic [NODE_W-1:0]        node_b,
    input  logic signed [VAL_W-1:0]  edge_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [COST_W-1:0] cost,
    output logic signed [VAL_W-1:0]  old_weight,
    output logic                     status
);

    localparam int EDGE_DEPTH = MAX_NODES * (MAX_NODES - 1) / 2;
    localparam int AW = (EDGE_DEPTH > 1) ? $clog2(EDGE_DEPTH) : 1;
    localparam int NW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int XW = (CW > NCNT_W) ? CW : NCNT_W;
    localparam int WB = WEIGHT_BITS;
    localparam int PW = WB + SCALE_W;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_FILL = 3'd2;
    localparam logic [2:0] ST_SCAN = 3'd3;
    localparam logic [2:0] ST_EX   = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;
    localparam logic [2:0] ST_ACC  = 3'd6;
    localparam logic [2:0] ST_DONE = 3'd7;

    function automatic logic [AW-1:0] pair_idx(input logic [NW-1:0] x, input logic [NW-1:0] y);
        logic [NW-1:0]   h, l;
        logic [2*NW-1:0] p;
        h = (x > y) ? x : y;
        l = (x > y) ? y : x;
        p = (2*NW)'(h) * (2*NW)'(h - 1'b1);
        return AW'((p >> 1) + (2*NW)'(l));
    endfunction

    // Registers
    logic [2:0]              state_reg, state_next;
    logic [NCNT_W-1:0]       ncount_reg, ncount_next;
    logic [SCALE_W-1:0]      scale_reg, scale_next;
    logic signed [VAL_W-1:0] bonus_reg, bonus_next;
    logic [MAX_NODES-1:0]    live_reg, live_next;
    logic [AW:0]             clr_reg, clr_next;
    logic [AW:0]             flim_reg, flim_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [NW-1:0]           lo_reg, lo_next, hi_reg, hi_next;
    logic [WB-1:0]           val_reg, val_next;
    logic                    first_reg, first_next;
    logic [CW-1:0]           i_reg, i_next;
    logic [WB-1:0]           mag_reg, mag_next;
    logic [COST_W-1:0]       bd_reg, bd_next;
    logic [PW-1:0]           prod_reg, prod_next;
    logic [COST_W-1:0]       cost_reg, cost_next;
    logic [WB-1:0]           oldw_reg, oldw_next;
    logic                    stat_reg, stat_next;
    logic                    ovld_reg, ovld_next;
    logic [COST_W-1:0]       ocost_reg, ocost_next;
    logic [WB-1:0]           oold_reg, oold_next;
    logic                    ostat_reg, ostat_next;

    // Combinational
    logic [NW-1:0]   a_n, b_n, lo_in, hi_in, i_n;
    logic [XW-1:0]   a_x, b_x, hi_x, nc_x;
    logic [CW-1:0]   nc;
    logic [2*CW-1:0] ncp;
    logic            in_range, accept, scan_end, skip;
    logic [AW-1:0]   addr_a, addr_b, wr_addr;
    logic [WB-1:0]   wr_data, rd_a, rd_b, w_new, mag;
    logic            we;
    logic [COST_W-1:0] bd;
    alu_mode_t       mode;
    logic signed [WB-1:0] oold_s;

    // Node decode and effective count
    assign a_n   = NW'(node_a);
    assign b_n   = NW'(node_b);
    assign a_x   = XW'(node_a);
    assign b_x   = XW'(node_b);
    assign lo_in = (a_n < b_n) ? a_n : b_n;
    assign hi_in = (a_n < b_n) ? b_n : a_n;
    assign hi_x  = (a_x < b_x) ? b_x : a_x;
    assign nc_x  = (ncount_reg < NCNT_W'(2)) ? XW'(2) :
                   (XW'(ncount_reg) > XW'(MAX_NODES)) ? XW'(MAX_NODES) : XW'(ncount_reg);
    assign nc       = CW'(nc_x);
    assign ncp      = (2*CW)'(nc) * (2*CW)'(nc - 1'b1);
    assign in_range = hi_x < nc_x;
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    // Loop addressing
    assign i_n      = i_reg[NW-1:0];
    assign scan_end = (i_reg == nc);
    assign skip     = (i_n == lo_reg) || (i_n == hi_reg) || !live_reg[i_n];
    assign addr_a   = first_reg ? pair_idx(lo_reg, hi_reg) : pair_idx(lo_reg, i_n);
    assign addr_b   = pair_idx(hi_reg, i_n);

    always_comb
    begin
        if (first_reg)
        begin
            mode = (op_reg == OP_REPL) ? ALU_REPL : ALU_MFIRST;
        end
        else
        begin
            mode = (op_reg == OP_MERGE) ? ALU_MERGE : ALU_SPLIT;
        end
    end

    wgm_cost_alu #(.WEIGHT_BITS(WB)) u_alu (
        .mode        (mode),
        .e1          (rd_a),
        .e2          (rd_b),
        .val         (val_reg),
        .bonus       (bonus_reg),
        .w_new       (w_new),
        .mag         (mag),
        .bonus_delta (bd)
    );

    // Edge memory write port
    always_comb
    begin
        we      = 1'b0;
        wr_addr = addr_a;
        wr_data = w_new;
        case (state_reg)
            ST_CLR:
            begin
                we      = 1'b1;
                wr_addr = clr_reg[AW-1:0];
                wr_data = '1;
            end
            ST_FILL:
            begin
                we      = 1'b1;
                wr_addr = clr_reg[AW-1:0];
                wr_data = val_reg;
            end
            ST_IDLE:
            begin
                we      = accept && (opcode == OP_WRITE) && (node_a != node_b) && in_range;
                wr_addr = pair_idx(a_n, b_n);
                wr_data = edge_value[WB-1:0];
            end
            ST_EX:
            begin
                we = (op_reg != OP_READ) && !((op_reg == OP_MERGE) && first_reg);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    wgm_edge_mem #(.DEPTH(EDGE_DEPTH), .AW(AW), .DW(WB)) u_mem (
        .clk       (clk),
        .we        (we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (addr_a),
        .rd_addr_b (addr_b),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b)
    );

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        ncount_next = ncount_reg;
        scale_next  = scale_reg;
        bonus_next  = bonus_reg;
        live_next   = live_reg;
        clr_next    = clr_reg;
        flim_next   = flim_reg;
        op_next     = op_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        val_next    = val_reg;
        first_next  = first_reg;
        i_next      = i_reg;
        mag_next    = mag_reg;
        bd_next     = bd_reg;
        prod_next   = prod_reg;
        cost_next   = cost_reg;
        oldw_next   = oldw_reg;
        stat_next   = stat_reg;
        ovld_next   = ovld_reg;
        ocost_next  = ocost_reg;
        oold_next   = oold_reg;
        ostat_next  = ostat_reg;

        // Configuration writes
        if (cfg_write)
        begin
            case (cfg_index)
                REG_NODE_COUNT: ncount_next = cfg_data[NCNT_W-1:0];
                REG_COST_SCALE: scale_next  = cfg_data[SCALE_W-1:0];
                REG_ZERO_BONUS: bonus_next  = cfg_data;
                default:        ncount_next = ncount_reg;
            endcase
        end

        // Drop a taken word
        if (ovld_reg && out_ready)
        begin
            ovld_next = 1'b0;
        end

        case (state_reg)
            ST_CLR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == (AW+1)'(EDGE_DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next    = opcode;
                    lo_next    = lo_in;
                    hi_next    = hi_in;
                    val_next   = edge_value[WB-1:0];
                    first_next = 1'b1;
                    i_next     = '0;
                    cost_next  = '0;
                    oldw_next  = '0;
                    stat_next  = 1'b0;
                    state_next = ST_DONE;
                    if (opcode == OP_FILL)
                    begin
                        clr_next  = '0;
                        flim_next = (AW+1)'(ncp >> 1);
                        for (int k = 0; k < MAX_NODES; k++)
                        begin
                            live_next[k] = (CW'(k) < nc);
                        end
                        state_next = ST_FILL;
                    end
                    else if (opcode < OP_FILL)
                    begin
                        if (node_a == node_b)
                        begin
                            stat_next = 1'b1;
                        end
                        else if (in_range)
                        begin
                            case (opcode)
                                OP_READ, OP_REPL:
                                begin
                                    state_next = ST_SCAN;
                                end
                                OP_MERGE:
                                begin
                                    if (live_reg[lo_in] && live_reg[hi_in])
                                    begin
                                        state_next = ST_SCAN;
                                    end
                                end
                                OP_SPLIT:
                                begin
                                    if (live_reg[lo_in] && !live_reg[hi_in])
                                    begin
                                        first_next = 1'b0;
                                        state_next = ST_SCAN;
                                    end
                                end
                                default:
                                begin
                                    state_next = ST_DONE;
                                end
                            endcase
                        end
                    end
                end
            end
            ST_FILL:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == flim_reg - 1'b1)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (first_reg)
                begin
                    state_next = ST_EX;
                end
                else if (scan_end)
                begin
                    live_next[hi_reg] = (op_reg == OP_SPLIT);
                    state_next        = ST_DONE;
                end
                else if (skip)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_EX;
                end
            end
            ST_EX:
            begin
                if (op_reg == OP_READ)
                begin
                    oldw_next  = rd_a;
                    state_next = ST_DONE;
                end
                else if (op_reg == OP_SPLIT)
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SCAN;
                end
                else
                begin
                    mag_next   = mag;
                    bd_next    = bd;
                    if (op_reg == OP_REPL)
                    begin
                        oldw_next = rd_a;
                    end
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PW'(mag_reg) * PW'(scale_reg);
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cost_next = cost_reg + COST_W'(prod_reg) + bd_reg;
                if (op_reg == OP_REPL)
                begin
                    state_next = ST_DONE;
                end
                else if (first_reg)
                begin
                    first_next = 1'b0;
                    state_next = ST_SCAN;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_DONE:
            begin
                if (!ovld_reg || out_ready)
                begin
                    ovld_next  = 1'b1;
                    ocost_next = cost_reg;
                    oold_next  = oldw_reg;
                    ostat_next = stat_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLR;
            ncount_reg <= NODE_COUNT_RST;
            scale_reg  <= COST_SCALE_RST;
            bonus_reg  <= '0;
            live_reg   <= '1;
            clr_reg    <= '0;
            ovld_reg   <= 1'b0;
            first_reg  <= 1'b0;
            i_reg      <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            ncount_reg <= ncount_next;
            scale_reg  <= scale_next;
            bonus_reg  <= bonus_next;
            live_reg   <= live_next;
            clr_reg    <= clr_next;
            ovld_reg   <= ovld_next;
            first_reg  <= first_next;
            i_reg      <= i_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        flim_reg  <= flim_next;
        op_reg    <= op_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        val_reg   <= val_next;
        mag_reg   <= mag_next;
        bd_reg    <= bd_next;
        prod_reg  <= prod_next;
        cost_reg  <= cost_next;
        oldw_reg  <= oldw_next;
        stat_reg  <= stat_next;
        ocost_reg <= ocost_next;
        oold_reg  <= oold_next;
        ostat_reg <= ostat_next;
    end

    assign oold_s     = oold_reg;
    assign out_valid  = ovld_reg;
    assign cost       = ocost_reg;
    assign old_weight = VAL_W'(oold_s);
    assign status     = ostat_reg;

    `WGM_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, accept, !in_ready, "word taken while busy")
    `WGM_ASSERT_NOW(a_clear_blocks, clk, rst_n, state_reg == ST_CLR, !in_ready, "input open during clear")
    `WGM_ASSERT_NOW(a_first_ops, clk, rst_n, (state_reg == ST_EX) && first_reg,
        (op_reg == OP_READ) || (op_reg == OP_REPL) || (op_reg == OP_MERGE), "bad first edge op")

endmodule
